/* hdl/tmbe_pkg.sv */
// Shared constants for the triangle monomial basis evaluator.
// No dependencies; used by the top level and the term emitter.
`default_nettype none

package tmbe_pkg;

  // Parameter defaults
  localparam int MAX_ORDER_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int IDX_W = 6;
  localparam int CFG_W = 4;

  // Order register after reset
  localparam logic [CFG_W-1:0] ORDER_RST = 4'd1;

endpackage

`default_nettype wire

/* hdl/tmbe_rmul.sv */
// Fixed-point multiply with round to nearest, ties away from zero.
// Operands and result are signed Q1.F with magnitude at most one. No dependencies.
`default_nettype none

module tmbe_rmul #(
  parameter int FRAC_BITS = 16
) (
  input  logic signed [FRAC_BITS+1:0] a,
  input  logic signed [FRAC_BITS+1:0] b,
  output logic signed [FRAC_BITS+1:0] p
);

  localparam int CW = FRAC_BITS + 2;
  localparam int MW = FRAC_BITS + 1;
  localparam int PW = 2 * MW;

  logic          neg;
  logic [MW-1:0] ma;
  logic [MW-1:0] mb;
  logic [PW-1:0] prod;
  logic [PW-1:0] rsum;
  logic [MW-1:0] rmag;

  // round on the magnitude, apply the sign afterwards
  always_comb begin
    neg  = a[CW-1] ^ b[CW-1];
    ma   = a[CW-1] ? MW'(-a) : MW'(a);
    mb   = b[CW-1] ? MW'(-b) : MW'(b);
    prod = PW'(ma) * PW'(mb);
    rsum = prod + (PW'(1) << (FRAC_BITS - 1));
    rmag = rsum[FRAC_BITS +: MW];
    p    = neg ? (CW'(0) - CW'(rmag)) : CW'(rmag);
  end

endmodule

`default_nettype wire

/* hdl/tmbe_cell.sv */
// One cell of the power chain: forms the next power of x and y as a point passes.
// Holds the working powers and the copy the emitter reads. Uses tmbe_rmul.
`default_nettype none

module tmbe_cell #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tok_in,
  input  logic                        load,
  input  logic signed [FRAC_BITS+1:0] px_in,
  input  logic signed [FRAC_BITS+1:0] py_in,
  input  logic signed [FRAC_BITS+1:0] cx_in,
  input  logic signed [FRAC_BITS+1:0] cy_in,
  output logic                        tok_out,
  output logic signed [FRAC_BITS+1:0] px_out,
  output logic signed [FRAC_BITS+1:0] py_out,
  output logic signed [FRAC_BITS+1:0] cx_out,
  output logic signed [FRAC_BITS+1:0] cy_out,
  output logic signed [FRAC_BITS+1:0] ex_out,
  output logic signed [FRAC_BITS+1:0] ey_out
);

  logic                        tok_r;
  logic signed [FRAC_BITS+1:0] wx_r;
  logic signed [FRAC_BITS+1:0] wy_r;
  logic signed [FRAC_BITS+1:0] cx_r;
  logic signed [FRAC_BITS+1:0] cy_r;
  logic signed [FRAC_BITS+1:0] ex_r;
  logic signed [FRAC_BITS+1:0] ey_r;
  logic signed [FRAC_BITS+1:0] wx_nxt;
  logic signed [FRAC_BITS+1:0] wy_nxt;

  tmbe_rmul #(.FRAC_BITS(FRAC_BITS)) u_mul_x (.a(px_in), .b(cx_in), .p(wx_nxt));
  tmbe_rmul #(.FRAC_BITS(FRAC_BITS)) u_mul_y (.a(py_in), .b(cy_in), .p(wy_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  // advance the wave; hold values until the next point passes
  always_ff @(posedge clk) begin
    if (tok_in) begin
      wx_r <= wx_nxt;
      wy_r <= wy_nxt;
      cx_r <= cx_in;
      cy_r <= cy_in;
    end
    if (load) begin
      ex_r <= wx_r;
      ey_r <= wy_r;
    end
  end

  assign tok_out = tok_r;
  assign px_out  = wx_r;
  assign py_out  = wy_r;
  assign cx_out  = cx_r;
  assign cy_out  = cy_r;
  assign ex_out  = ex_r;
  assign ey_out  = ey_r;

endmodule

`default_nettype wire

/* hdl/tmbe_emit.sv */
// Term sequencer and result pipeline: walks (degree, i), forms value and gradients.
// Reads the power bank held in the chain cells. Uses tmbe_pkg and tmbe_rmul.
`default_nettype none

module tmbe_emit #(
  parameter int MAX_ORDER = tmbe_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = tmbe_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 pend,
  output logic                                 take,
  input  logic [$clog2(MAX_ORDER+1)-1:0]       ord_in,
  input  logic signed [FRAC_BITS+1:0]          bank_x [MAX_ORDER+1],
  input  logic signed [FRAC_BITS+1:0]          bank_y [MAX_ORDER+1],
  output logic                                 out_valid,
  output logic [tmbe_pkg::IDX_W-1:0]           out_basis_index,
  output logic signed [FRAC_BITS+1:0]          out_basis_value,
  output logic signed [FRAC_BITS+4:0]          out_grad_x,
  output logic signed [FRAC_BITS+4:0]          out_grad_y,
  output logic                                 out_last_basis
);

  localparam int CTW = $clog2(MAX_ORDER + 1);
  localparam int CW  = FRAC_BITS + 2;
  localparam int GW  = FRAC_BITS + 5;
  localparam int IW  = tmbe_pkg::IDX_W;

  // sequencer
  logic           act_r, act_nxt;
  logic [CTW-1:0] d_r, d_nxt;
  logic [CTW-1:0] i_r, i_nxt;
  logic [CTW-1:0] ord_r, ord_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [CTW-1:0] j_cur;
  logic           last_cur;
  logic signed [CW-1:0] x_sel;
  logic signed [CW-1:0] y_sel;

  // stage 1: selected powers
  logic                 v1_r;
  logic [CTW-1:0]       i1_r, j1_r;
  logic [IW-1:0]        idx1_r;
  logic                 last1_r;
  logic signed [CW-1:0] x1_r, y1_r, xp1_r;

  // stage 2: rounded products
  logic                 v2_r;
  logic [CTW-1:0]       i2_r, j2_r;
  logic [IW-1:0]        idx2_r;
  logic                 last2_r;
  logic signed [CW-1:0] val_nxt, rgx_nxt, rgy_nxt;
  logic signed [CW-1:0] val2_r, rgx2_r, rgy2_r;

  // output stage
  logic                 ov_r;
  logic [IW-1:0]        oidx_r;
  logic signed [CW-1:0] oval_r;
  logic signed [GW-1:0] ogx_r, ogy_r;
  logic                 olast_r;
  logic signed [GW-1:0] gx_nxt, gy_nxt;

  always_comb begin
    j_cur    = d_r - i_r;
    last_cur = act_r && (d_r == ord_r) && (i_r == d_r);
    take     = pend && (!act_r || last_cur);
    x_sel    = bank_x[i_r];
    y_sel    = bank_y[j_cur];

    act_nxt = act_r;
    d_nxt   = d_r;
    i_nxt   = i_r;
    ord_nxt = ord_r;
    idx_nxt = idx_r;
    if (take) begin
      act_nxt = 1'b1;
      d_nxt   = '0;
      i_nxt   = '0;
      idx_nxt = '0;
      ord_nxt = ord_in;
    end else if (act_r) begin
      idx_nxt = idx_r + IW'(1);
      if (last_cur) begin
        act_nxt = 1'b0;
      end else if (i_r == d_r) begin
        d_nxt = d_r + CTW'(1);
        i_nxt = '0;
      end else begin
        i_nxt = i_r + CTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      d_r   <= '0;
      i_r   <= '0;
      ord_r <= '0;
      idx_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      d_r   <= d_nxt;
      i_r   <= i_nxt;
      ord_r <= ord_nxt;
      idx_r <= idx_nxt;
      v1_r  <= act_r;
      v2_r  <= v1_r;
      ov_r  <= v2_r;
    end
  end

  // Terms of one point issue without gaps, so the previous x power is the
  // last one captured, and the y power one step lower is the one now selected.
  tmbe_rmul #(.FRAC_BITS(FRAC_BITS)) u_mul_v (.a(x1_r),  .b(y1_r),  .p(val_nxt));
  tmbe_rmul #(.FRAC_BITS(FRAC_BITS)) u_mul_x (.a(xp1_r), .b(y1_r),  .p(rgx_nxt));
  tmbe_rmul #(.FRAC_BITS(FRAC_BITS)) u_mul_y (.a(x1_r),  .b(y_sel), .p(rgy_nxt));

  always_comb begin
    gx_nxt = '0;
    gy_nxt = '0;
    if (i2_r != '0) begin
      gx_nxt = GW'(rgx2_r) * GW'($signed({1'b0, i2_r}));
    end
    if (j2_r != '0) begin
      gy_nxt = GW'(rgy2_r) * GW'($signed({1'b0, j2_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (act_r) begin
      i1_r    <= i_r;
      j1_r    <= j_cur;
      idx1_r  <= idx_r;
      last1_r <= last_cur;
      x1_r    <= x_sel;
      y1_r    <= y_sel;
      xp1_r   <= x1_r;
    end
    i2_r    <= i1_r;
    j2_r    <= j1_r;
    idx2_r  <= idx1_r;
    last2_r <= last1_r;
    val2_r  <= val_nxt;
    rgx2_r  <= rgx_nxt;
    rgy2_r  <= rgy_nxt;
    oidx_r  <= idx2_r;
    oval_r  <= val2_r;
    ogx_r   <= gx_nxt;
    ogy_r   <= gy_nxt;
    olast_r <= last2_r;
  end

  assign out_valid       = ov_r;
  assign out_basis_index = oidx_r;
  assign out_basis_value = oval_r;
  assign out_grad_x      = ogx_r;
  assign out_grad_y      = ogy_r;
  assign out_last_basis  = olast_r & ov_r;

endmodule

`default_nettype wire

/* hdl/triangle_monomial_basis_eval_core.sv */
// Top level of the triangle monomial basis evaluator with gradient.
// Depends on tmbe_pkg, tmbe_cell (power chain) and tmbe_emit (term pipeline).
`default_nettype none

// A point (x, y) in signed Q1.F is taken when start is high and busy is low;
// both coordinates are clamped to [-1, 1]. For every monomial x^i*y^j of total
// degree 0..poly_order (values above MAX_ORDER act as MAX_ORDER) one result
// transaction comes out, ordered by degree and then by ascending i, with the
// index, the value and both partial derivatives; last_basis marks the final
// term of the point. Each result is present for exactly one cycle with
// out_valid high, and the receiver cannot stall: it must take every result.
// Results of one point leave at one per clock; a point of order n yields
// (n+1)(n+2)/2 results through the single result slot. A point passes the
// input register, the MAX_ORDER chain cells and a hand-over register, then
// the emitter's sequencer, stage 1, stage 2 and output stage. The next point
// is taken while the current one is still emitting; if its powers are held
// ready by that one's last term, its first result follows without a gap.
// poly_order is written through the cfg channel, which is always ready;
// write it only while the block is idle.

module triangle_monomial_basis_eval_core #(
  parameter int MAX_ORDER = tmbe_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = tmbe_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // point input
  input  logic                              start,
  output logic                              busy,
  input  logic signed [FRAC_BITS+1:0]       in_x_coord,
  input  logic signed [FRAC_BITS+1:0]       in_y_coord,
  // results
  output logic                              out_valid,
  output logic [tmbe_pkg::IDX_W-1:0]        out_basis_index,
  output logic signed [FRAC_BITS+1:0]       out_basis_value,
  output logic signed [FRAC_BITS+4:0]       out_grad_x,
  output logic signed [FRAC_BITS+4:0]       out_grad_y,
  output logic                              out_last_basis,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tmbe_pkg::CFG_W-1:0]        cfg_poly_order
);

  localparam int CTW = $clog2(MAX_ORDER + 1);
  localparam int CW  = FRAC_BITS + 2;
  localparam int OW  = tmbe_pkg::CFG_W;

  localparam logic signed [CW-1:0] ONE_FX     = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [CW-1:0] NEG_ONE_FX = {2'b11, {FRAC_BITS{1'b0}}};

  logic [OW-1:0]  poly_order_r;
  logic [CTW-1:0] ord_eff;

  logic                 tok0_r;
  logic signed [CW-1:0] cx0_r, cy0_r;
  logic signed [CW-1:0] cx_clamp, cy_clamp;
  logic                 accept;

  logic                 pend_r, pend_nxt;
  logic                 take;

  // chain wires: position 0 is the input register, k is cell k
  logic [MAX_ORDER:0]   tok_w;
  logic signed [CW-1:0] px_w [MAX_ORDER+1];
  logic signed [CW-1:0] py_w [MAX_ORDER+1];
  logic signed [CW-1:0] cx_w [MAX_ORDER+1];
  logic signed [CW-1:0] cy_w [MAX_ORDER+1];

  // power bank for the emitter; the zeroth power is the constant one
  logic signed [CW-1:0] bank_x [MAX_ORDER+1];
  logic signed [CW-1:0] bank_y [MAX_ORDER+1];

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_order_r <= tmbe_pkg::ORDER_RST;
    end else if (cfg_valid && cfg_ready) begin
      poly_order_r <= cfg_poly_order;
    end
  end

  assign ord_eff = (poly_order_r > OW'(MAX_ORDER)) ? CTW'(MAX_ORDER) : CTW'(poly_order_r);

  // Busy while a point is in the chain or waits for the emitter to take it.
  assign busy   = (|tok_w) | pend_r;
  assign accept = start & ~busy;

  // clamp coordinates to [-1, 1]
  always_comb begin
    cx_clamp = in_x_coord;
    if (in_x_coord > ONE_FX) begin
      cx_clamp = ONE_FX;
    end else if (in_x_coord < NEG_ONE_FX) begin
      cx_clamp = NEG_ONE_FX;
    end
    cy_clamp = in_y_coord;
    if (in_y_coord > ONE_FX) begin
      cy_clamp = ONE_FX;
    end else if (in_y_coord < NEG_ONE_FX) begin
      cy_clamp = NEG_ONE_FX;
    end
  end

  // Hold the finished powers until the emitter takes them.
  assign pend_nxt = tok_w[MAX_ORDER] | (pend_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      tok0_r <= accept;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx0_r <= cx_clamp;
      cy0_r <= cy_clamp;
    end
  end

  assign tok_w[0]  = tok0_r;
  assign px_w[0]   = ONE_FX;
  assign py_w[0]   = ONE_FX;
  assign cx_w[0]   = cx0_r;
  assign cy_w[0]   = cy0_r;
  assign bank_x[0] = ONE_FX;
  assign bank_y[0] = ONE_FX;

  // power chain: cell k forms x^k and y^k from its left neighbor
  for (genvar k = 1; k <= MAX_ORDER; k++) begin : g_cell
    tmbe_cell #(
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok_w[k-1]),
      .load    (take),
      .px_in   (px_w[k-1]),
      .py_in   (py_w[k-1]),
      .cx_in   (cx_w[k-1]),
      .cy_in   (cy_w[k-1]),
      .tok_out (tok_w[k]),
      .px_out  (px_w[k]),
      .py_out  (py_w[k]),
      .cx_out  (cx_w[k]),
      .cy_out  (cy_w[k]),
      .ex_out  (bank_x[k]),
      .ey_out  (bank_y[k])
    );
  end

  // term sequencer and result pipeline
  tmbe_emit #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .pend            (pend_r),
    .take            (take),
    .ord_in          (ord_eff),
    .bank_x          (bank_x),
    .bank_y          (bank_y),
    .out_valid       (out_valid),
    .out_basis_index (out_basis_index),
    .out_basis_value (out_basis_value),
    .out_grad_x      (out_grad_x),
    .out_grad_y      (out_grad_y),
    .out_last_basis  (out_last_basis)
  );

endmodule

`default_nettype wire
